### hdl/m4at_pkg.sv
// ----------------------------------------------------------------------------
// m4at_pkg
// Shared constants, command codes and control types of the mat4 transform unit.
// ----------------------------------------------------------------------------
package m4at_pkg;

	localparam int FRAC_BITS_DEF    = 16;
	localparam int CORDIC_STEPS_DEF = 16;
	localparam int ATAN_ENTRIES     = 30;

	// Q30 angle constants
	localparam logic [33:0] Q30_PI          = 34'd3373259426;
	localparam logic [33:0] Q30_TWO_PI      = 34'd6746518852;
	localparam logic [33:0] Q30_HALF_PI     = 34'd1686629713;
	localparam logic [33:0] Q30_CORDIC_GAIN = 34'd652032874;

	localparam logic [2:0] FN_LOAD      = 3'd0;
	localparam logic [2:0] FN_IDENTITY  = 3'd1;
	localparam logic [2:0] FN_SCALE     = 3'd2;
	localparam logic [2:0] FN_ROTATE    = 3'd3;
	localparam logic [2:0] FN_TRANSLATE = 3'd4;

	localparam logic [4:0] OP_NOP     = 5'd0;
	localparam logic [4:0] OP_LOAD    = 5'd1;
	localparam logic [4:0] OP_LATCH   = 5'd2;
	localparam logic [4:0] OP_IDENT   = 5'd3;
	localparam logic [4:0] OP_COPY    = 5'd4;
	localparam logic [4:0] OP_COMMIT  = 5'd5;
	localparam logic [4:0] OP_CLR     = 5'd6;
	localparam logic [4:0] OP_MUL_MV  = 5'd7;
	localparam logic [4:0] OP_MUL_MN  = 5'd8;
	localparam logic [4:0] OP_MUL_VV  = 5'd9;
	localparam logic [4:0] OP_LDU     = 5'd10;
	localparam logic [4:0] OP_MUL_UR  = 5'd11;
	localparam logic [4:0] OP_MUL_RT  = 5'd12;
	localparam logic [4:0] OP_MUL_US  = 5'd13;
	localparam logic [4:0] OP_ADD_RAW = 5'd14;
	localparam logic [4:0] OP_ADD_Q   = 5'd15;
	localparam logic [4:0] OP_SUB_Q   = 5'd16;
	localparam logic [4:0] OP_ADD_M   = 5'd17;
	localparam logic [4:0] OP_ADD_C   = 5'd18;
	localparam logic [4:0] OP_TMP     = 5'd19;
	localparam logic [4:0] OP_WR_D    = 5'd20;
	localparam logic [4:0] OP_WR_DQ   = 5'd21;
	localparam logic [4:0] OP_WR_N    = 5'd22;
	localparam logic [4:0] OP_SQRT    = 5'd23;
	localparam logic [4:0] OP_DIV_U   = 5'd24;
	localparam logic [4:0] OP_WR_U    = 5'd25;
	localparam logic [4:0] OP_U_BYP   = 5'd26;
	localparam logic [4:0] OP_MOD     = 5'd27;
	localparam logic [4:0] OP_CORD    = 5'd28;
	localparam logic [4:0] OP_TRIG    = 5'd29;

	typedef struct packed {
		logic [4:0] op;
		logic [3:0] i0;
		logic [3:0] i1;
	} m4at_cmd_t;

	typedef struct packed {
		logic busy;
		logic len_zero;
	} m4at_sts_t;

	function automatic logic [31:0] atan_q30(input logic [4:0] i);
		case (i)
			5'd0:  atan_q30 = 32'h3243F6A8;
			5'd1:  atan_q30 = 32'h1DAC6705;
			5'd2:  atan_q30 = 32'h0FADBAFC;
			5'd3:  atan_q30 = 32'h07F56EA6;
			5'd4:  atan_q30 = 32'h03FEAB76;
			5'd5:  atan_q30 = 32'h01FFD55B;
			5'd6:  atan_q30 = 32'h00FFFAAA;
			5'd7:  atan_q30 = 32'h007FFF55;
			5'd8:  atan_q30 = 32'h003FFFEA;
			5'd9:  atan_q30 = 32'h001FFFFD;
			5'd10: atan_q30 = 32'h000FFFFF;
			5'd11: atan_q30 = 32'h0007FFFF;
			5'd12: atan_q30 = 32'h0003FFFF;
			5'd13: atan_q30 = 32'h0001FFFF;
			5'd14: atan_q30 = 32'h0000FFFF;
			5'd15: atan_q30 = 32'h00007FFF;
			5'd16: atan_q30 = 32'h00003FFF;
			5'd17: atan_q30 = 32'h00001FFF;
			5'd18: atan_q30 = 32'h00000FFF;
			5'd19: atan_q30 = 32'h000007FF;
			5'd20: atan_q30 = 32'h000003FF;
			5'd21: atan_q30 = 32'h000001FF;
			5'd22: atan_q30 = 32'h000000FF;
			5'd23: atan_q30 = 32'h0000007F;
			5'd24: atan_q30 = 32'h0000003F;
			5'd25: atan_q30 = 32'h0000001F;
			5'd26: atan_q30 = 32'h0000000F;
			5'd27: atan_q30 = 32'h00000008;
			5'd28: atan_q30 = 32'h00000004;
			5'd29: atan_q30 = 32'h00000002;
			default: atan_q30 = 32'h00000000;
		endcase
	endfunction

endpackage

### hdl/m4at_dp.sv
// ----------------------------------------------------------------------------
// m4at_dp
// Datapath: matrix registers, shared multiplier and accumulator, bit-serial
// square root and divider, angle range reduction, CORDIC rotator.
// ----------------------------------------------------------------------------
module m4at_dp #(
	parameter int FRAC_BITS    = m4at_pkg::FRAC_BITS_DEF,
	parameter int CORDIC_STEPS = m4at_pkg::CORDIC_STEPS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  m4at_pkg::m4at_cmd_t cmd,
	output m4at_pkg::m4at_sts_t sts,
	input  logic [3:0]          elem_sel,
	input  logic signed [31:0]  load_value,
	input  logic signed [31:0]  vec_x,
	input  logic signed [31:0]  vec_y,
	input  logic signed [31:0]  vec_z,
	input  logic signed [31:0]  angle,
	output logic signed [31:0]  out_value
);
	import m4at_pkg::*;

	localparam int SH     = 30 - FRAC_BITS;
	localparam int NSTEPS = (CORDIC_STEPS < ATAN_ENTRIES) ? CORDIC_STEPS : ATAN_ENTRIES;
	localparam logic [4:0] LAST_STEP = 5'(NSTEPS - 1);
	localparam logic [4:0] MOD_TOP   = 5'(SH);
	localparam logic signed [31:0] ONE = 32'sd1 <<< FRAC_BITS;

	function automatic logic signed [31:0] sat_acc(input logic signed [65:0] v);
		if (v > 66'sd2147483647)
			sat_acc = 32'sh7FFFFFFF;
		else if (v < -66'sd2147483648)
			sat_acc = 32'sh80000000;
		else
			sat_acc = v[31:0];
	endfunction

	function automatic logic [31:0] mag32(input logic signed [31:0] v);
		mag32 = v[31] ? 32'(-v) : 32'(v);
	endfunction

	logic signed [31:0] m_q [16];
	logic signed [31:0] d_q [16];
	logic signed [31:0] n_q [9];
	logic signed [31:0] v_q [3];
	logic signed [31:0] u_q [3];
	logic signed [31:0] ang_q, r_q, s_q, c_q, t_q;
	logic signed [63:0] p_q;
	logic signed [65:0] acc_q;

	logic [63:0] sq_n_q;
	logic [35:0] sq_rem_q;
	logic [31:0] sq_root_q;
	logic [4:0]  sq_cnt_q;
	logic        sq_run_q;

	logic [63:0] dv_q;
	logic [34:0] dv_rem_q;
	logic [33:0] dv_dvs_q;
	logic [5:0]  dv_cnt_q;
	logic        dv_run_q;

	logic [63:0] md_rem_q;
	logic [4:0]  md_k_q;
	logic        md_run_q;

	logic signed [33:0] co_x_q, co_y_q;
	logic signed [35:0] co_z_q;
	logic [4:0]         co_i_q;
	logic               co_run_q, co_neg_q;

	// multiplier operands
	logic signed [31:0] mul_a, mul_b;
	logic               mul_en;
	always_comb begin
		mul_a  = m_q[cmd.i0];
		mul_b  = v_q[cmd.i1[1:0]];
		mul_en = 1'b1;
		case (cmd.op)
			OP_MUL_MV: begin
			end
			OP_MUL_MN: mul_b = n_q[cmd.i1];
			OP_MUL_VV: mul_a = v_q[cmd.i1[1:0]];
			OP_MUL_UR: begin
				mul_a = u_q[cmd.i1[1:0]];
				mul_b = r_q;
			end
			OP_MUL_RT: begin
				mul_a = r_q;
				mul_b = t_q;
			end
			OP_MUL_US: begin
				mul_a = u_q[cmd.i1[1:0]];
				mul_b = s_q;
			end
			default: mul_en = 1'b0;
		endcase
	end

	logic signed [63:0] p_sh;
	logic signed [31:0] qp;
	always_comb begin
		p_sh = p_q >>> FRAC_BITS;
		if (p_sh > 64'sd2147483647)
			qp = 32'sh7FFFFFFF;
		else if (p_sh < -64'sd2147483648)
			qp = 32'sh80000000;
		else
			qp = p_sh[31:0];
	end

	// unit component from quotient
	logic [32:0]        qc;
	logic signed [33:0] qneg;
	logic signed [31:0] unit_val;
	logic signed [31:0] v_sel;
	always_comb begin
		v_sel = v_q[cmd.i1[1:0]];
		qc    = (dv_q > 64'h80000000) ? 33'h080000000 : dv_q[32:0];
		qneg  = -$signed({1'b0, qc});
		if (v_sel[31])
			unit_val = qneg[31:0];
		else if (qc[32] | qc[31])
			unit_val = 32'sh7FFFFFFF;
		else
			unit_val = qc[31:0];
	end

	// angle reduction into [-pi/2, pi/2]
	logic signed [35:0] z0, z1, z2;
	logic               fold;
	always_comb begin
		z0 = ang_q[31] ? -$signed({3'b0, md_rem_q[32:0]}) : $signed({3'b0, md_rem_q[32:0]});
		if (z0 > $signed({2'b0, Q30_PI}))
			z1 = z0 - $signed({2'b0, Q30_TWO_PI});
		else if (z0 < -$signed({2'b0, Q30_PI}))
			z1 = z0 + $signed({2'b0, Q30_TWO_PI});
		else
			z1 = z0;
		fold = 1'b1;
		if (z1 > $signed({2'b0, Q30_HALF_PI}))
			z2 = z1 - $signed({2'b0, Q30_PI});
		else if (z1 < -$signed({2'b0, Q30_HALF_PI}))
			z2 = z1 + $signed({2'b0, Q30_PI});
		else begin
			z2   = z1;
			fold = 1'b0;
		end
	end

	logic signed [33:0] xf, yf, xr, yr, tw;
	always_comb begin
		xf = co_neg_q ? -co_x_q : co_x_q;
		yf = co_neg_q ? -co_y_q : co_y_q;
		xr = (xf + (34'sd1 <<< (SH - 1))) >>> SH;
		yr = (yf + (34'sd1 <<< (SH - 1))) >>> SH;
		tw = 34'(ONE) - xr;
	end

	logic signed [33:0] co_xs, co_ys;
	logic signed [35:0] co_at;
	assign co_xs = co_x_q >>> co_i_q;
	assign co_ys = co_y_q >>> co_i_q;
	assign co_at = $signed({4'b0, atan_q30(co_i_q)});

	logic [35:0] sq_rem2, sq_trial;
	assign sq_rem2  = {sq_rem_q[33:0], sq_n_q[63:62]};
	assign sq_trial = {2'b0, sq_root_q, 2'b01};

	logic [34:0] dv_rem2;
	assign dv_rem2 = {dv_rem_q[33:0], dv_q[63]};

	// shifted 2*pi for the compare and subtract reduction
	logic [63:0] md_sub;
	assign md_sub = 64'(Q30_TWO_PI) << md_k_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < 16; k++)
				m_q[k] <= (k % 5 == 0) ? ONE : 32'sd0;
			sq_run_q <= 1'b0;
			dv_run_q <= 1'b0;
			md_run_q <= 1'b0;
			co_run_q <= 1'b0;
		end else begin
			case (cmd.op)
				OP_LOAD:   m_q[elem_sel] <= load_value;
				OP_COMMIT: m_q <= d_q;
				OP_SQRT:   sq_run_q <= 1'b1;
				OP_DIV_U:  dv_run_q <= 1'b1;
				OP_MOD:    md_run_q <= 1'b1;
				OP_CORD:   co_run_q <= 1'b1;
				default: begin
				end
			endcase
			if (sq_run_q && sq_cnt_q == 5'd31)
				sq_run_q <= 1'b0;
			if (dv_run_q && dv_cnt_q == 6'd63)
				dv_run_q <= 1'b0;
			if (md_run_q && md_k_q == 5'd0)
				md_run_q <= 1'b0;
			if (co_run_q && co_i_q == LAST_STEP)
				co_run_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (mul_en)
			p_q <= mul_a * mul_b;
		case (cmd.op)
			OP_LATCH: begin
				v_q[0] <= vec_x;
				v_q[1] <= vec_y;
				v_q[2] <= vec_z;
				ang_q  <= angle;
			end
			OP_IDENT:
				for (int k = 0; k < 16; k++)
					d_q[k] <= (k % 5 == 0) ? ONE : 32'sd0;
			OP_COPY:    d_q <= m_q;
			OP_CLR:     acc_q <= '0;
			OP_ADD_RAW: acc_q <= acc_q + 66'(p_q);
			OP_ADD_Q:   acc_q <= acc_q + 66'(qp);
			OP_SUB_Q:   acc_q <= acc_q - 66'(qp);
			OP_ADD_M:   acc_q <= acc_q + 66'(m_q[cmd.i0]);
			OP_ADD_C:   acc_q <= acc_q + 66'(c_q);
			OP_LDU:     r_q <= u_q[cmd.i1[1:0]];
			OP_TMP:     r_q <= qp;
			OP_WR_D:    d_q[cmd.i0] <= sat_acc(acc_q);
			OP_WR_DQ:   d_q[cmd.i0] <= qp;
			OP_WR_N:    n_q[cmd.i0] <= sat_acc(acc_q);
			OP_WR_U:    u_q[cmd.i1[1:0]] <= unit_val;
			OP_U_BYP:   u_q <= v_q;
			OP_SQRT: begin
				sq_n_q    <= acc_q[63:0];
				sq_rem_q  <= '0;
				sq_root_q <= '0;
				sq_cnt_q  <= '0;
			end
			OP_DIV_U: begin
				dv_q     <= 64'(mag32(v_sel)) << FRAC_BITS;
				dv_rem_q <= '0;
				dv_dvs_q <= {2'b0, sq_root_q};
				dv_cnt_q <= '0;
			end
			OP_MOD: begin
				md_rem_q <= 64'(mag32(ang_q)) << SH;
				md_k_q   <= MOD_TOP;
			end
			OP_CORD: begin
				co_x_q   <= $signed(Q30_CORDIC_GAIN);
				co_y_q   <= '0;
				co_z_q   <= z2;
				co_neg_q <= fold;
				co_i_q   <= '0;
			end
			OP_TRIG: begin
				s_q <= yr[31:0];
				c_q <= xr[31:0];
				t_q <= tw[31:0];
			end
			default: begin
			end
		endcase
		if (sq_run_q) begin
			sq_n_q   <= {sq_n_q[61:0], 2'b00};
			sq_cnt_q <= sq_cnt_q + 5'd1;
			if (sq_rem2 >= sq_trial) begin
				sq_rem_q  <= sq_rem2 - sq_trial;
				sq_root_q <= {sq_root_q[30:0], 1'b1};
			end else begin
				sq_rem_q  <= sq_rem2;
				sq_root_q <= {sq_root_q[30:0], 1'b0};
			end
		end
		if (dv_run_q) begin
			dv_cnt_q <= dv_cnt_q + 6'd1;
			if (dv_rem2 >= {1'b0, dv_dvs_q}) begin
				dv_rem_q <= dv_rem2 - {1'b0, dv_dvs_q};
				dv_q     <= {dv_q[62:0], 1'b1};
			end else begin
				dv_rem_q <= dv_rem2;
				dv_q     <= {dv_q[62:0], 1'b0};
			end
		end
		if (md_run_q) begin
			md_k_q <= md_k_q - 5'd1;
			if (md_rem_q >= md_sub)
				md_rem_q <= md_rem_q - md_sub;
		end
		if (co_run_q) begin
			co_i_q <= co_i_q + 5'd1;
			if (!co_z_q[35]) begin
				co_x_q <= co_x_q - co_ys;
				co_y_q <= co_y_q + co_xs;
				co_z_q <= co_z_q - co_at;
			end else begin
				co_x_q <= co_x_q + co_ys;
				co_y_q <= co_y_q - co_xs;
				co_z_q <= co_z_q + co_at;
			end
		end
	end

	assign sts.busy     = sq_run_q | dv_run_q | md_run_q | co_run_q;
	assign sts.len_zero = (sq_root_q == '0);
	assign out_value    = d_q[cmd.i0];

endmodule

### hdl/m4at_ctrl.sv
// ----------------------------------------------------------------------------
// m4at_ctrl
// Sequencer: steps the datapath through each transform and emits the matrix.
// ----------------------------------------------------------------------------
module m4at_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [2:0]          func,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [3:0]          out_index,
	output logic                last,
	output m4at_pkg::m4at_cmd_t cmd,
	input  m4at_pkg::m4at_sts_t sts
);
	import m4at_pkg::*;

	localparam logic [5:0] ST_IDLE    = 6'd0;
	localparam logic [5:0] ST_START   = 6'd1;
	localparam logic [5:0] ST_SC_MUL  = 6'd2;
	localparam logic [5:0] ST_SC_WR   = 6'd3;
	localparam logic [5:0] ST_TR_CLR  = 6'd4;
	localparam logic [5:0] ST_TR_MUL  = 6'd5;
	localparam logic [5:0] ST_TR_ACC  = 6'd6;
	localparam logic [5:0] ST_TR_ADDM = 6'd7;
	localparam logic [5:0] ST_TR_WR   = 6'd8;
	localparam logic [5:0] ST_RO_CLR  = 6'd9;
	localparam logic [5:0] ST_RO_SQ   = 6'd10;
	localparam logic [5:0] ST_RO_SQA  = 6'd11;
	localparam logic [5:0] ST_RO_SQRT = 6'd12;
	localparam logic [5:0] ST_RO_SQW  = 6'd13;
	localparam logic [5:0] ST_RO_UBYP = 6'd14;
	localparam logic [5:0] ST_RO_DIV  = 6'd15;
	localparam logic [5:0] ST_RO_DIVW = 6'd16;
	localparam logic [5:0] ST_RO_WRU  = 6'd17;
	localparam logic [5:0] ST_RO_MOD  = 6'd18;
	localparam logic [5:0] ST_RO_MODW = 6'd19;
	localparam logic [5:0] ST_RO_CORD = 6'd20;
	localparam logic [5:0] ST_RO_CORW = 6'd21;
	localparam logic [5:0] ST_RO_TRIG = 6'd22;
	localparam logic [5:0] ST_N_CLR   = 6'd23;
	localparam logic [5:0] ST_N_LDU   = 6'd24;
	localparam logic [5:0] ST_N_MUL1  = 6'd25;
	localparam logic [5:0] ST_N_TMP   = 6'd26;
	localparam logic [5:0] ST_N_MUL2  = 6'd27;
	localparam logic [5:0] ST_N_ACC1  = 6'd28;
	localparam logic [5:0] ST_N_ADDC  = 6'd29;
	localparam logic [5:0] ST_N_MUL3  = 6'd30;
	localparam logic [5:0] ST_N_ACC2  = 6'd31;
	localparam logic [5:0] ST_N_WR    = 6'd32;
	localparam logic [5:0] ST_M_CLR   = 6'd33;
	localparam logic [5:0] ST_M_MUL   = 6'd34;
	localparam logic [5:0] ST_M_ACC   = 6'd35;
	localparam logic [5:0] ST_M_WR    = 6'd36;
	localparam logic [5:0] ST_COMMIT  = 6'd37;
	localparam logic [5:0] ST_EMIT    = 6'd38;

	logic [5:0] state_q, state_d;
	logic [2:0] func_q, func_d;
	logic [3:0] e_q, e_d;
	logic [1:0] j_q, j_d, k_q, k_d, c_q, c_d;

	logic [3:0] n_idx;
	logic [1:0] other, next_c;
	logic       in_acc;

	assign in_ready = (state_q == ST_IDLE);
	assign in_acc   = in_valid & in_ready;
	assign n_idx    = {2'b0, c_q} + {1'b0, c_q, 1'b0} + {2'b0, j_q};
	assign other    = 2'd3 - j_q - c_q;
	assign next_c   = (c_q == 2'd2) ? 2'd0 : c_q + 2'd1;

	always_comb begin
		state_d = state_q;
		func_d  = func_q;
		e_d     = e_q;
		j_d     = j_q;
		k_d     = k_q;
		c_d     = c_q;
		cmd.op  = OP_NOP;
		cmd.i0  = '0;
		cmd.i1  = '0;
		case (state_q)
			ST_IDLE: if (in_acc) begin
				func_d = func;
				if (func == FN_LOAD)
					cmd.op = OP_LOAD;
				else if (func inside {FN_IDENTITY, FN_SCALE, FN_ROTATE, FN_TRANSLATE}) begin
					cmd.op  = OP_LATCH;
					state_d = ST_START;
				end
			end
			ST_START: begin
				e_d = '0;
				j_d = '0;
				k_d = '0;
				c_d = '0;
				cmd.op = (func_q == FN_IDENTITY) ? OP_IDENT : OP_COPY;
				case (func_q)
					FN_SCALE:  state_d = ST_SC_MUL;
					FN_ROTATE: state_d = ST_RO_CLR;
					FN_TRANSLATE: state_d = ST_TR_CLR;
					default:   state_d = ST_COMMIT;
				endcase
			end
			ST_SC_MUL: begin
				cmd.op  = OP_MUL_MV;
				cmd.i0  = e_q;
				cmd.i1  = {2'b0, e_q[3:2]};
				state_d = ST_SC_WR;
			end
			ST_SC_WR: begin
				cmd.op = OP_WR_DQ;
				cmd.i0 = e_q;
				e_d    = e_q + 4'd1;
				state_d = (e_q == 4'd11) ? ST_COMMIT : ST_SC_MUL;
			end
			ST_TR_CLR: begin
				cmd.op  = OP_CLR;
				j_d     = '0;
				state_d = ST_TR_MUL;
			end
			ST_TR_MUL: begin
				cmd.op  = OP_MUL_MV;
				cmd.i0  = {j_q, k_q};
				cmd.i1  = {2'b0, j_q};
				state_d = ST_TR_ACC;
			end
			ST_TR_ACC: begin
				cmd.op = OP_ADD_Q;
				j_d    = j_q + 2'd1;
				state_d = (j_q == 2'd2) ? ST_TR_ADDM : ST_TR_MUL;
			end
			ST_TR_ADDM: begin
				cmd.op  = OP_ADD_M;
				cmd.i0  = {2'b11, k_q};
				state_d = ST_TR_WR;
			end
			ST_TR_WR: begin
				cmd.op  = OP_WR_D;
				cmd.i0  = {2'b11, k_q};
				k_d     = k_q + 2'd1;
				state_d = (k_q == 2'd3) ? ST_COMMIT : ST_TR_CLR;
			end
			ST_RO_CLR: begin
				cmd.op  = OP_CLR;
				j_d     = '0;
				state_d = ST_RO_SQ;
			end
			ST_RO_SQ: begin
				cmd.op  = OP_MUL_VV;
				cmd.i1  = {2'b0, j_q};
				state_d = ST_RO_SQA;
			end
			ST_RO_SQA: begin
				cmd.op  = OP_ADD_RAW;
				j_d     = j_q + 2'd1;
				state_d = (j_q == 2'd2) ? ST_RO_SQRT : ST_RO_SQ;
			end
			ST_RO_SQRT: begin
				cmd.op  = OP_SQRT;
				j_d     = '0;
				state_d = ST_RO_SQW;
			end
			ST_RO_SQW: if (!sts.busy)
				state_d = sts.len_zero ? ST_RO_UBYP : ST_RO_DIV;
			ST_RO_UBYP: begin
				cmd.op  = OP_U_BYP;
				state_d = ST_RO_MOD;
			end
			ST_RO_DIV: begin
				cmd.op  = OP_DIV_U;
				cmd.i1  = {2'b0, j_q};
				state_d = ST_RO_DIVW;
			end
			ST_RO_DIVW: if (!sts.busy)
				state_d = ST_RO_WRU;
			ST_RO_WRU: begin
				cmd.op  = OP_WR_U;
				cmd.i1  = {2'b0, j_q};
				j_d     = j_q + 2'd1;
				state_d = (j_q == 2'd2) ? ST_RO_MOD : ST_RO_DIV;
			end
			ST_RO_MOD: begin
				cmd.op  = OP_MOD;
				state_d = ST_RO_MODW;
			end
			ST_RO_MODW: if (!sts.busy)
				state_d = ST_RO_CORD;
			ST_RO_CORD: begin
				cmd.op  = OP_CORD;
				state_d = ST_RO_CORW;
			end
			ST_RO_CORW: if (!sts.busy)
				state_d = ST_RO_TRIG;
			ST_RO_TRIG: begin
				cmd.op  = OP_TRIG;
				j_d     = '0;
				c_d     = '0;
				state_d = ST_N_CLR;
			end
			// rotation matrix term n[3c+r]; j is r, c is the column
			ST_N_CLR: begin
				cmd.op  = OP_CLR;
				state_d = ST_N_LDU;
			end
			ST_N_LDU: begin
				cmd.op  = OP_LDU;
				cmd.i1  = {2'b0, c_q};
				state_d = ST_N_MUL1;
			end
			ST_N_MUL1: begin
				cmd.op  = OP_MUL_UR;
				cmd.i1  = {2'b0, j_q};
				state_d = ST_N_TMP;
			end
			ST_N_TMP: begin
				cmd.op  = OP_TMP;
				state_d = ST_N_MUL2;
			end
			ST_N_MUL2: begin
				cmd.op  = OP_MUL_RT;
				state_d = ST_N_ACC1;
			end
			ST_N_ACC1: begin
				cmd.op  = OP_ADD_Q;
				state_d = (j_q == c_q) ? ST_N_ADDC : ST_N_MUL3;
			end
			ST_N_ADDC: begin
				cmd.op  = OP_ADD_C;
				state_d = ST_N_WR;
			end
			ST_N_MUL3: begin
				cmd.op  = OP_MUL_US;
				cmd.i1  = {2'b0, other};
				state_d = ST_N_ACC2;
			end
			ST_N_ACC2: begin
				cmd.op  = (j_q == next_c) ? OP_ADD_Q : OP_SUB_Q;
				state_d = ST_N_WR;
			end
			ST_N_WR: begin
				cmd.op = OP_WR_N;
				cmd.i0 = n_idx;
				state_d = ST_N_CLR;
				if (j_q == 2'd2) begin
					j_d = '0;
					if (c_q == 2'd2) begin
						c_d     = '0;
						k_d     = '0;
						state_d = ST_M_CLR;
					end else
						c_d = c_q + 2'd1;
				end else
					j_d = j_q + 2'd1;
			end
			// d[4col+k] = sum over j of m[k+4j] * n[3col+j]; c is col
			ST_M_CLR: begin
				cmd.op  = OP_CLR;
				j_d     = '0;
				state_d = ST_M_MUL;
			end
			ST_M_MUL: begin
				cmd.op  = OP_MUL_MN;
				cmd.i0  = {j_q, k_q};
				cmd.i1  = n_idx;
				state_d = ST_M_ACC;
			end
			ST_M_ACC: begin
				cmd.op  = OP_ADD_Q;
				j_d     = j_q + 2'd1;
				state_d = (j_q == 2'd2) ? ST_M_WR : ST_M_MUL;
			end
			ST_M_WR: begin
				cmd.op  = OP_WR_D;
				cmd.i0  = {c_q, k_q};
				k_d     = k_q + 2'd1;
				state_d = ST_M_CLR;
				if (k_q == 2'd3) begin
					c_d = c_q + 2'd1;
					if (c_q == 2'd2)
						state_d = ST_COMMIT;
				end
			end
			ST_COMMIT: begin
				cmd.op  = OP_COMMIT;
				e_d     = '0;
				state_d = ST_EMIT;
			end
			ST_EMIT: begin
				cmd.i0 = e_q;
				if (out_ready) begin
					e_d = e_q + 4'd1;
					if (e_q == 4'd15)
						state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			func_q  <= FN_LOAD;
			e_q     <= '0;
			j_q     <= '0;
			k_q     <= '0;
			c_q     <= '0;
		end else begin
			state_q <= state_d;
			func_q  <= func_d;
			e_q     <= e_d;
			j_q     <= j_d;
			k_q     <= k_d;
			c_q     <= c_d;
		end
	end

	assign out_valid = (state_q == ST_EMIT);
	assign out_index = e_q;
	assign last      = out_valid && (e_q == 4'd15);

	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_ready && out_valid))
		else $error("input and output active together");
	a_last_to_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_ready && last) |=> in_ready)
		else $error("not idle after final word");
	a_load_silent: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready && func == FN_LOAD) |=> (in_ready && !out_valid))
		else $error("load item produced activity");
	a_emit_cont: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_ready && !last) |=> (out_valid && out_index == $past(out_index) + 4'd1))
		else $error("matrix emission broken");

endmodule

### hdl/mat4_affine_transform_unit.sv
// ----------------------------------------------------------------------------
// mat4_affine_transform_unit
// 4x4 Q-format transform matrix with identity, scale, rotate and translate.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_ready) takes one word per command; output channel
// (out_valid/out_ready) returns the 16 elements of the new matrix in
// column-major order, last high on element 15.
// One command is processed at a time; in_ready is high only while idle.
// Load and unknown commands give no output. Rotate runs the bit-serial
// square root, the bit-serial divider for each of the three axis divisions
// (skipped for a zero-length axis), the angle reduction, the CORDIC steps
// and 63 multiply passes through one multiplier.
// Output gives one element per cycle while out_ready is high;
// a stall on out_ready holds the current element and the whole unit.
// Reset loads the identity matrix and returns to idle.
// ----------------------------------------------------------------------------
module mat4_affine_transform_unit #(
	parameter int FRAC_BITS    = m4at_pkg::FRAC_BITS_DEF,
	parameter int CORDIC_STEPS = m4at_pkg::CORDIC_STEPS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [2:0]         func,
	input  logic [3:0]         elem_sel,
	input  logic signed [31:0] load_value,
	input  logic signed [31:0] vec_x,
	input  logic signed [31:0] vec_y,
	input  logic signed [31:0] vec_z,
	input  logic signed [31:0] angle,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [3:0]         out_index,
	output logic signed [31:0] out_value,
	output logic               last
);
	import m4at_pkg::*;

	m4at_cmd_t cmd;
	m4at_sts_t sts;

	m4at_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.func      (func),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_index (out_index),
		.last      (last),
		.cmd       (cmd),
		.sts       (sts)
	);

	m4at_dp #(
		.FRAC_BITS    (FRAC_BITS),
		.CORDIC_STEPS (CORDIC_STEPS)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.sts        (sts),
		.elem_sel   (elem_sel),
		.load_value (load_value),
		.vec_x      (vec_x),
		.vec_y      (vec_y),
		.vec_z      (vec_z),
		.angle      (angle),
		.out_value  (out_value)
	);

endmodule
